// ----- sv/fsr_pkg.sv -----
`default_nettype none

package fsr_pkg;

    // Bytes in one frame: id, voltage, current, twelve axes, checksum.
    localparam int unsigned FRAME_BYTES = 16;
    localparam int unsigned FRAME_W     = FRAME_BYTES * 8;
    localparam int unsigned BODY_W      = FRAME_W - 8;
    localparam int unsigned BYTE_CNT_W  = 4;

    // Counter value of the last checksum step (fifteen body bytes).
    localparam logic [BYTE_CNT_W-1:0] CSUM_LAST = 4'd14;
    // Counter value of the sixteenth byte of a frame.
    localparam logic [BYTE_CNT_W-1:0] SEND_LAST = 4'd15;

    // Item operations.
    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_SEND     = 2'd1;
    localparam logic [1:0] OP_FEEDBACK = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ACK  = 1'b0;
    localparam logic CFG_NACK = 1'b1;

    // Configuration reset values ('A' and 'N').
    localparam logic [7:0] ACK_RESET  = 8'd65;
    localparam logic [7:0] NACK_RESET = 8'd78;

    // Result kinds.
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CSUM,
        ST_STORE,
        ST_FETCH,
        ST_SEND
    } t_state;

endpackage

`default_nettype wire

// ----- sv/fsr_frame_ram.sv -----
`default_nettype none

module fsr_frame_ram
    import fsr_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_we,
    input  wire  [$clog2(SLOT_COUNT)-1:0] i_waddr,
    input  wire  [FRAME_W-1:0]           i_wdata,
    input  wire                          i_re,
    input  wire  [$clog2(SLOT_COUNT)-1:0] i_raddr,
    output logic [FRAME_W-1:0]           o_rdata
);

    // One row holds a whole frame; a per-row valid bit stands in for the
    // all-zero contents after reset.
    logic [FRAME_W-1:0]    r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;
    logic [FRAME_W-1:0]    r_rd_row;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_row <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_row : '0;

endmodule

`default_nettype wire

// ----- sv/frame_sender_with_ack_resend_unit.sv -----
`default_nettype none

// Channel       Direction  Ports                                  Transfer
// ------------  ---------  -------------------------------------  ------------------------
// item          in         start, busy, i_opcode .. i_feedback_*  start high, busy low
// result        out        o_valid, o_result_kind, o_frame_byte,  o_valid high, one cycle
//                          o_last_byte
// configuration in         i_cfg_we, i_cfg_idx, i_cfg_data        i_cfg_we high
//
// After its transfer a sample keeps busy high through the passes of the byte-serial
// checksum unit, one per body byte, and the write of the frame row. A send tick on a
// non-empty ring keeps it high through one memory read and the sending of sixteen bytes.
// Results leave through a register in the following cycle. Feedback, an empty-ring send
// tick and an unused opcode finish in the cycle of the transfer. Reset is synchronous and
// active low; it clears the ring pointers and the per-slot valid bits and loads the codes
// with their reset values at once, so there is no clearing pass. The receiver cannot stall.

module frame_sender_with_ack_resend_unit
    import fsr_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_opcode,
    input  wire  [7:0]  i_voltage_byte,
    input  wire  [7:0]  i_current_byte,
    input  wire  [47:0] i_accel_first_half,
    input  wire  [47:0] i_accel_second_half,
    input  wire  [7:0]  i_feedback_code,
    input  wire  [4:0]  i_feedback_frame,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_result_kind,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    // Ring pointers and configuration.
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_tail;
    logic [SW-1:0] r_acked;
    logic [7:0]    r_ack_code;
    logic [7:0]    r_nack_code;

    // Sequencer.
    t_state              r_state;
    t_state              n_state;
    logic [BYTE_CNT_W-1:0] r_cnt;

    // Frame body being checksummed and the running checksum.
    logic [BODY_W-1:0] r_body;
    logic [7:0]        r_sum;

    // Result register.
    logic       r_out_vld;
    logic       r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic              accept;
    logic              ring_empty;
    logic              ring_full;
    logic              do_csum;
    logic              do_store;
    logic              do_fetch;
    logic              do_send;
    logic [SW-1:0]     fb_tab [32];
    logic [SW-1:0]     fb_id;
    logic [FRAME_W-1:0] rd_row;

    function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    assign accept     = start && !busy;
    assign ring_empty = (r_head == r_tail);
    assign ring_full  = (r_acked == slot_next(r_tail));

    // The partner's frame id is taken modulo the ring depth. The id has five bits,
    // so a constant table of 32 entries holds every reduced value.
    for (genvar v = 0; v < 32; v++) begin : g_fb_tab
        assign fb_tab[v] = SW'(v % SLOT_COUNT);
    end
    assign fb_id = fb_tab[i_feedback_frame];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_SAMPLE) begin
                        n_state = ST_CSUM;
                    end else if (i_opcode == OP_SEND && !ring_empty) begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_CSUM: begin
                if (r_cnt == CSUM_LAST) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: n_state = ST_IDLE;
            ST_FETCH: n_state = ST_SEND;
            ST_SEND: begin
                if (r_cnt == SEND_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Decoded controls of the sequencer.
    always_comb begin
        busy     = 1'b1;
        do_csum  = 1'b0;
        do_store = 1'b0;
        do_fetch = 1'b0;
        do_send  = 1'b0;
        case (r_state)
            ST_IDLE:  busy     = 1'b0;
            ST_CSUM:  do_csum  = 1'b1;
            ST_STORE: do_store = 1'b1;
            ST_FETCH: do_fetch = 1'b1;
            ST_SEND:  do_send  = 1'b1;
            default:  busy     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_code  <= ACK_RESET;
            r_nack_code <= NACK_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ACK) begin
                r_ack_code <= i_cfg_data;
            end else begin
                r_nack_code <= i_cfg_data;
            end
        end
    end

    // Ring pointers. Feedback is handled in the transfer cycle itself; an equal
    // ack and nack code counts as an ack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_acked <= '0;
        end else begin
            if (accept && i_opcode == OP_FEEDBACK) begin
                if (i_feedback_code == r_ack_code) begin
                    r_acked <= fb_id;
                end else if (i_feedback_code == r_nack_code) begin
                    r_acked <= fb_id;
                    r_head  <= fb_id;
                end
            end
            // On a full ring the tail stays, so the next sample overwrites it.
            if (do_store && !ring_full) begin
                r_tail <= slot_next(r_tail);
            end
            if (do_send && r_cnt == SEND_LAST) begin
                r_head <= slot_next(r_head);
            end
        end
    end

    // Byte counter shared by the checksum and the transmit loop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (do_csum || do_send) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_cnt <= '0;
        end
    end

    // Byte-serial checksum unit. The body rotates one byte per step; after fifteen
    // steps it is back in its original order, ready to be written.
    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == OP_SAMPLE) begin
            r_body <= {i_accel_second_half, i_accel_first_half,
                       i_current_byte, i_voltage_byte, 8'(r_tail)};
            r_sum  <= '0;
        end else if (do_csum) begin
            r_body <= {r_body[7:0], r_body[BODY_W-1:8]};
            r_sum  <= r_sum ^ r_body[7:0];
        end
    end

    fsr_frame_ram #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (do_store),
        .i_waddr (r_tail),
        .i_wdata ({r_sum, r_body}),
        .i_re    (do_fetch),
        .i_raddr (r_head),
        .o_rdata (rd_row)
    );

    // Result register: frame bytes in order, or one buffer-full notice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= do_send || (do_store && ring_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_send) begin
            r_out_kind <= KIND_BYTE;
            r_out_byte <= rd_row[{r_cnt, 3'b000} +: 8];
            r_out_last <= (r_cnt == SEND_LAST);
        end else begin
            r_out_kind <= KIND_NOTICE;
            r_out_byte <= '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result_kind = r_out_kind;
    assign o_frame_byte  = r_out_byte;
    assign o_last_byte   = r_out_last;

endmodule

`default_nettype wire
